@@ rtl/midq_pkg.sv @@
package midq_pkg;

  localparam int unsigned CAPACITY    = 1024;
  localparam int unsigned LEFT_DEPTH  = CAPACITY / 2;
  localparam int unsigned RIGHT_DEPTH = (CAPACITY + 1) / 2;

  localparam int unsigned LEFT_AW  = (LEFT_DEPTH > 1) ? $clog2(LEFT_DEPTH) : 1;
  localparam int unsigned RIGHT_AW = (RIGHT_DEPTH > 1) ? $clog2(RIGHT_DEPTH) : 1;
  localparam int unsigned LCNT_W   = $clog2(LEFT_DEPTH + 1);
  localparam int unsigned RCNT_W   = $clog2(RIGHT_DEPTH + 1);
  localparam int unsigned SIZE_W   = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;

  typedef enum logic [1:0] {
    OP_PUSH_BACK   = 2'd0,
    OP_PUSH_FRONT  = 2'd1,
    OP_PUSH_MIDDLE = 2'd2,
    OP_GET         = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic                re;
    logic [LEFT_AW-1:0]  raddr;
    logic                we;
    logic [LEFT_AW-1:0]  waddr;
    logic [DATA_W-1:0]   wdata;
  } lram_req_t;

  typedef struct packed {
    logic                re;
    logic [RIGHT_AW-1:0] raddr;
    logic                we;
    logic [RIGHT_AW-1:0] waddr;
    logic [DATA_W-1:0]   wdata;
  } rram_req_t;

endpackage

@@ rtl/midq_ram.sv @@
module midq_ram #(
  parameter int unsigned DEPTH = 512,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/midq_ctrl.sv @@
module midq_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    opcode_i,
  input  logic [31:0]                   operand_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [31:0]                   read_value_o,
  output logic [1:0]                    status_o,
  output midq_pkg::lram_req_t           lreq_o,
  input  logic [midq_pkg::DATA_W-1:0]   lrdata_i,
  output midq_pkg::rram_req_t           rreq_o,
  input  logic [midq_pkg::DATA_W-1:0]   rrdata_i
);
  import midq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  function automatic logic [LEFT_AW-1:0] l_wrap(input logic [LCNT_W:0] s);
    logic [LCNT_W:0] t;
    t = (s >= (LCNT_W+1)'(LEFT_DEPTH)) ? s - (LCNT_W+1)'(LEFT_DEPTH) : s;
    return t[LEFT_AW-1:0];
  endfunction

  function automatic logic [RIGHT_AW-1:0] r_wrap(input logic [RCNT_W:0] s);
    logic [RCNT_W:0] t;
    t = (s >= (RCNT_W+1)'(RIGHT_DEPTH)) ? s - (RCNT_W+1)'(RIGHT_DEPTH) : s;
    return t[RIGHT_AW-1:0];
  endfunction

  function automatic logic [LEFT_AW-1:0] l_dec(input logic [LEFT_AW-1:0] h);
    return (h == '0) ? LEFT_AW'(LEFT_DEPTH - 1) : h - 1'b1;
  endfunction

  function automatic logic [RIGHT_AW-1:0] r_dec(input logic [RIGHT_AW-1:0] h);
    return (h == '0) ? RIGHT_AW'(RIGHT_DEPTH - 1) : h - 1'b1;
  endfunction

  function automatic logic [RIGHT_AW-1:0] r_inc(input logic [RIGHT_AW-1:0] h);
    return (h == RIGHT_AW'(RIGHT_DEPTH - 1)) ? '0 : h + 1'b1;
  endfunction

  state_e              state_q, state_d;
  logic [LEFT_AW-1:0]  lhead_q, lhead_d;
  logic [RIGHT_AW-1:0] rhead_q, rhead_d;
  logic [LCNT_W-1:0]   lcnt_q, lcnt_d;
  logic [RCNT_W-1:0]   rcnt_q, rcnt_d;
  opcode_e             op_q;
  logic [31:0]         arg_q;
  logic                out_valid_q;
  logic [31:0]         value_q, value_d;
  status_e             status_q, status_d;

  logic [SIZE_W-1:0]   size;
  logic                balanced, right_heavy, full;
  logic                accept, fire;
  opcode_e             op_in;
  logic                in_range_i, from_left_i;
  logic                in_range_q, from_left_q;
  logic [SIZE_W-1:0]   roff_i;
  logic [RIGHT_AW-1:0] rhead_pop;
  logic [RCNT_W-1:0]   rcnt_pop;

  assign size        = SIZE_W'(lcnt_q) + SIZE_W'(rcnt_q);
  assign balanced    = SIZE_W'(rcnt_q) == SIZE_W'(lcnt_q);
  assign right_heavy = !balanced;
  assign full        = size >= SIZE_W'(CAPACITY);

  assign in_ready_o = state_q == S_IDLE;
  assign accept     = in_valid_i && in_ready_o;
  assign fire       = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);

  assign op_in       = opcode_e'(opcode_i);
  assign in_range_i  = !operand_i[31] && (operand_i < 32'(size));
  assign from_left_i = operand_i < 32'(lcnt_q);
  assign roff_i      = operand_i[SIZE_W-1:0] - SIZE_W'(lcnt_q);

  assign in_range_q  = !arg_q[31] && (arg_q < 32'(size));
  assign from_left_q = arg_q < 32'(lcnt_q);
  assign rhead_pop   = right_heavy ? r_inc(rhead_q) : rhead_q;
  assign rcnt_pop    = right_heavy ? rcnt_q - 1'b1 : rcnt_q;

  always_comb begin
    // read side, issued at the accept edge
    lreq_o.re = accept && (((op_in == OP_GET) && in_range_i && from_left_i) ||
                           ((op_in == OP_PUSH_FRONT) && balanced && (lcnt_q != '0)));
    rreq_o.re = accept && (((op_in == OP_GET) && in_range_i && !from_left_i) ||
                           (((op_in == OP_PUSH_BACK) || (op_in == OP_PUSH_MIDDLE)) &&
                            right_heavy));
    if (op_in == OP_GET) begin
      lreq_o.raddr = l_wrap((LCNT_W+1)'(lhead_q) + (LCNT_W+1)'(operand_i[LCNT_W-1:0]));
      rreq_o.raddr = r_wrap((RCNT_W+1)'(rhead_q) + (RCNT_W+1)'(roff_i[RCNT_W-1:0]));
    end else begin
      // back element of the left ring / front element of the right ring
      lreq_o.raddr = l_wrap((LCNT_W+1)'(lhead_q) + (LCNT_W+1)'(lcnt_q) - 1'b1);
      rreq_o.raddr = rhead_q;
    end

    // write-back and state update in the execute cycle
    state_d      = state_q;
    lhead_d      = lhead_q;
    rhead_d      = rhead_q;
    lcnt_d       = lcnt_q;
    rcnt_d       = rcnt_q;
    value_d      = value_q;
    status_d     = status_q;
    lreq_o.we    = 1'b0;
    lreq_o.waddr = l_wrap((LCNT_W+1)'(lhead_q) + (LCNT_W+1)'(lcnt_q));
    lreq_o.wdata = rrdata_i;
    rreq_o.we    = 1'b0;
    rreq_o.waddr = r_wrap((RCNT_W+1)'(rhead_pop) + (RCNT_W+1)'(rcnt_pop));
    rreq_o.wdata = arg_q;

    if (accept) begin
      state_d = S_EXEC;
    end

    if (fire) begin
      state_d  = S_IDLE;
      value_d  = '0;
      status_d = ST_OK;
      if (op_q == OP_GET) begin
        if (!in_range_q) begin
          status_d = ST_RANGE;
        end else begin
          value_d = from_left_q ? lrdata_i : rrdata_i;
        end
      end else if (full) begin
        status_d = ST_FULL;
      end else begin
        case (op_q) inside
          OP_PUSH_BACK, OP_PUSH_MIDDLE: begin
            // rebalance: right front moves to left back
            if (right_heavy) begin
              lreq_o.we = 1'b1;
              lcnt_d    = lcnt_q + 1'b1;
            end
            rreq_o.we = 1'b1;
            rcnt_d    = rcnt_pop + 1'b1;
            rhead_d   = rhead_pop;
            if (op_q == OP_PUSH_MIDDLE) begin
              rhead_d      = r_dec(rhead_pop);
              rreq_o.waddr = r_dec(rhead_pop);
            end
          end
          default: begin
            if (balanced && (lcnt_q == '0)) begin
              rreq_o.we    = 1'b1;
              rreq_o.waddr = r_dec(rhead_q);
              rhead_d      = r_dec(rhead_q);
              rcnt_d       = rcnt_q + 1'b1;
            end else begin
              lreq_o.we    = 1'b1;
              lreq_o.waddr = l_dec(lhead_q);
              lreq_o.wdata = arg_q;
              lhead_d      = l_dec(lhead_q);
              if (balanced) begin
                // left back moves to right front, left count unchanged
                rreq_o.we    = 1'b1;
                rreq_o.waddr = r_dec(rhead_q);
                rreq_o.wdata = lrdata_i;
                rhead_d      = r_dec(rhead_q);
                rcnt_d       = rcnt_q + 1'b1;
              end else begin
                lcnt_d = lcnt_q + 1'b1;
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lhead_q     <= '0;
      rhead_q     <= '0;
      lcnt_q      <= '0;
      rcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lhead_q <= lhead_d;
      rhead_q <= rhead_d;
      lcnt_q  <= lcnt_d;
      rcnt_q  <= rcnt_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_in;
      arg_q <= operand_i;
    end
    value_q  <= value_d;
    status_q <= status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = value_q;
  assign status_o     = status_q;

  balance_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (SIZE_W'(rcnt_q) == SIZE_W'(lcnt_q)) ||
    (SIZE_W'(rcnt_q) == SIZE_W'(lcnt_q) + 1'b1))
    else $error("halves out of balance");

  size_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    size <= SIZE_W'(CAPACITY))
    else $error("size above capacity");

  accept_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_EXEC) && !in_ready_o)
    else $error("accepted item not in execute");

  err_zero_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != ST_OK)) |-> (value_q == '0))
    else $error("failed command with nonzero value");

  push_size_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (op_q != OP_GET) && !full) |=> (size == $past(size) + 1'b1))
    else $error("push did not grow size by one");

endmodule

@@ rtl/middle_insert_indexed_deque.sv @@
// An accepted item enters the execute state; once the output register is free, its result
// is registered there. A new item is taken only after the previous one leaves the execute
// state; its ring entry is read from a synchronous memory, then modified and written back.
// A new item is taken while the previous result still waits in the output register.
// Reset (rst_ni, async, active low) empties both halves; memory contents are not cleared.
module middle_insert_indexed_deque (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         opcode_i,
  input  logic signed [31:0] operand_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] read_value_o,
  output logic [1:0]         status_o
);
  import midq_pkg::*;

  lram_req_t         lreq;
  rram_req_t         rreq;
  logic [DATA_W-1:0] lrdata;
  logic [DATA_W-1:0] rrdata;
  logic [31:0]       value;

  midq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .operand_i    (operand_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .read_value_o (value),
    .status_o     (status_o),
    .lreq_o       (lreq),
    .lrdata_i     (lrdata),
    .rreq_o       (rreq),
    .rrdata_i     (rrdata)
  );

  assign read_value_o = value;

  midq_ram #(
    .DEPTH (LEFT_DEPTH),
    .WIDTH (DATA_W),
    .AW    (LEFT_AW)
  ) u_left_ram (
    .clk_i   (clk_i),
    .re_i    (lreq.re),
    .raddr_i (lreq.raddr),
    .rdata_o (lrdata),
    .we_i    (lreq.we),
    .waddr_i (lreq.waddr),
    .wdata_i (lreq.wdata)
  );

  midq_ram #(
    .DEPTH (RIGHT_DEPTH),
    .WIDTH (DATA_W),
    .AW    (RIGHT_AW)
  ) u_right_ram (
    .clk_i   (clk_i),
    .re_i    (rreq.re),
    .raddr_i (rreq.raddr),
    .rdata_o (rrdata),
    .we_i    (rreq.we),
    .waddr_i (rreq.waddr),
    .wdata_i (rreq.wdata)
  );

endmodule
